### hdl/mcg_pkg.sv
// Shared types, constants and calendar tables for the month calendar grid.
package mcg_pkg;

  localparam int unsigned MCG_QUEUE_DEPTH = 2;
  localparam int unsigned GRID_SLOTS      = 42;
  localparam int unsigned REFORM_YEAR     = 1752;

  // Reciprocal of 25 scaled by 2^17, exact for dividends below 4096.
  localparam logic [12:0] RECIP25    = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;

  localparam logic [1:0] KIND_BLANK  = 2'd0;
  localparam logic [1:0] KIND_NORMAL = 2'd1;
  localparam logic [1:0] KIND_SEP    = 2'd2;

  localparam logic CFG_MONDAY_FIRST = 1'b0;
  localparam logic CFG_ORDINAL      = 1'b1;

  // One grid job as seen by the back end.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] pos;    // column of the first
    logic [4:0] dim;    // days in month
    logic [8:0] start;  // number printed on the first
  } mcg_entry_t;

  // Days before the first of month m in a common year.
  function automatic logic [8:0] month_cum(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:                    r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:      r = 5'd31;
      default:                 r = 5'd0;
    endcase
    return r;
  endfunction

  // Residue mod 7 by summing octal digits (8 is 1 mod 7).
  function automatic logic [2:0] mod7(input logic [14:0] v);
    logic [5:0] s;
    logic [3:0] f;
    s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
    f = 4'(s[2:0]) + 4'(s[5:3]);
    if (f >= 4'd7) f = f - 4'd7;
    return f[2:0];
  endfunction

  // September 1752, Sunday-first; the 2nd is followed by the 14th. 0 is blank.
  function automatic logic [4:0] sep_dom(input logic [5:0] idx);
    logic [4:0] r;
    if (idx == 6'd2)                        r = 5'd1;
    else if (idx == 6'd3)                   r = 5'd2;
    else if (idx >= 6'd4 && idx <= 6'd20)   r = 5'(idx + 6'd10);
    else                                    r = 5'd0;
    return r;
  endfunction

endpackage

### hdl/mcg_front.sv
// Front end: takes a month request and works out the grid job for the back end.
module mcg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_month,
  input  logic [13:0]         in_year,
  input  logic                monday_first,
  input  logic                ordinal_numbering,
  output logic                push_valid,
  input  logic                push_ready,
  output mcg_pkg::mcg_entry_t push_entry
);
  import mcg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]  state;
  logic [3:0]  month;
  logic [13:0] year;
  logic [13:0] n;
  logic [7:0]  qn;     // (year-1)/100
  logic [7:0]  qy;     // year/100
  logic [14:0] total;
  logic        leap;
  logic [8:0]  fdoy;
  logic [1:0]  kind;

  logic [24:0] prod_n, prod_y;
  logic        y4, y100, leap_next, after_gap;
  logic [12:0] leaps;
  logic [8:0]  fdoy_next;
  logic [2:0]  wd;

  assign n = year - 14'd1;
  assign prod_n = 25'(n[13:2]) * 25'(RECIP25);
  assign prod_y = 25'(year[13:2]) * 25'(RECIP25);

  always_comb begin
    y4   = (year[1:0] == 2'b00);
    y100 = y4 && (13'(year[13:2]) == 13'(qy) * 13'd25);
    if (year <= 14'(REFORM_YEAR)) begin
      leap_next = y4;
    end else begin
      leap_next = y4 && (!y100 || year[3:0] == 4'd0);
    end
    if (n <= 14'd1700) begin
      leaps = 13'(n[13:2]);
    end else begin
      leaps = 13'(n[13:2]) - 13'(qn) + 13'(qn[7:2]) + 13'd13;
    end
    fdoy_next = month_cum(month) + 9'd1 + 9'((leap_next && month > 4'd2) ? 1 : 0);
    after_gap = (year > 14'(REFORM_YEAR)) || (year == 14'(REFORM_YEAR) && month >= 4'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (in_valid) state <= ST_DIV;
        ST_DIV:  state <= ST_SUM;
        ST_SUM:  state <= ST_PUSH;
        ST_PUSH: if (push_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      month <= in_month;
      year  <= in_year;
    end
    if (state == ST_DIV) begin
      qn <= prod_n[RECIP_SHIFT+:8];
      qy <= prod_y[RECIP_SHIFT+:8];
      if (month == 4'd9 && year == 14'(REFORM_YEAR)) begin
        kind <= KIND_SEP;
      end else if (month >= 4'd1 && month <= 4'd12 && year != 14'd0) begin
        kind <= KIND_NORMAL;
      end else begin
        kind <= KIND_BLANK;
      end
    end
    if (state == ST_SUM) begin
      // 365 is 1 mod 7; weekday offset is 5 before the gap, 1 after it
      total <= 15'(n) + 15'(leaps) + 15'(fdoy_next) + (after_gap ? 15'd1 : 15'd5);
      leap  <= leap_next;
      fdoy  <= fdoy_next;
    end
  end

  assign wd = mod7(total);

  always_comb begin
    push_entry.kind  = kind;
    push_entry.pos   = monday_first ? ((wd == 3'd0) ? 3'd6 : wd - 3'd1) : wd;
    push_entry.dim   = month_days(month, leap);
    push_entry.start = ordinal_numbering ? fdoy : 9'd1;
  end

  assign in_ready   = (state == ST_IDLE);
  assign push_valid = (state == ST_PUSH);

endmodule

### hdl/mcg_queue.sv
// Small job queue between the front and back ends.
module mcg_queue #(
  parameter int unsigned DEPTH = mcg_pkg::MCG_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  mcg_pkg::mcg_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mcg_pkg::mcg_entry_t pop_entry
);
  import mcg_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mcg_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_ready && pop_valid;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

endmodule

### hdl/mcg_back.sv
// Back end: walks the 42 grid slots of one job into the output register.
module mcg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  mcg_pkg::mcg_entry_t pop_entry,
  input  logic                monday_first,
  input  logic                ordinal_numbering,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          out_slot,
  output logic                out_blank,
  output logic [8:0]          out_day,
  output logic                out_last
);
  import mcg_pkg::*;

  logic [5:0] slot;
  logic       advance, at_end;
  logic [5:0] rel, sep_idx;
  logic [4:0] dom;
  logic [8:0] day_next;

  assign advance   = pop_valid && (!out_valid || out_ready);
  assign at_end    = (slot == 6'(GRID_SLOTS - 1));
  assign pop_ready = advance && at_end;

  always_comb begin
    rel      = slot - 6'(pop_entry.pos);
    sep_idx  = slot + 6'(monday_first);
    dom      = sep_dom(sep_idx);
    day_next = 9'd0;
    case (pop_entry.kind)
      KIND_NORMAL: begin
        if (slot >= 6'(pop_entry.pos) && rel < 6'(pop_entry.dim))
          day_next = pop_entry.start + 9'(rel);
      end
      KIND_SEP: begin
        // day of year of the 1st is 245 and every later day keeps the same offset
        if (dom != 5'd0) day_next = ordinal_numbering ? 9'(dom) + 9'd244 : 9'(dom);
      end
      default: day_next = 9'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        slot      <= at_end ? 6'd0 : slot + 6'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_slot  <= slot;
      out_day   <= day_next;
      out_blank <= (day_next == 9'd0);
      out_last  <= at_end;
    end
  end

  a_last_on_final_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_slot == 6'(GRID_SLOTS - 1))))
    else $error("last flag does not match slot 41");

  a_blank_means_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_blank == (out_day == 9'd0)))
    else $error("blank flag and day value disagree");

  a_slot_in_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_slot == $past(out_slot) + 6'd1))
    else $error("grid slot skipped or stalled inside a grid");

endmodule

### hdl/month_calendar_grid.sv
// Top level of the month calendar grid: config registers and front/queue/back hookup.
//
//   channel  dir  handshake              payload
//   s_*      in   s_tvalid / s_tready    s_tdata: month[3:0], year[17:4]
//   m_*      out  m_tvalid / m_tready    m_tdata: slot_index, day_value; m_tuser: blank; m_tlast
//   cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request yields 42 items, one per cycle while m_tready is high, counted by the
// back end's slot counter. The front end takes each request through divide, sum and
// push states, accepts no new one until idle again, and runs ahead into a two-entry
// queue. Reset is synchronous and clears all control state and both config registers.
// A stall on m_tready holds the output register and, once the queue is full, s_tready.
module month_calendar_grid #(
  parameter int unsigned QUEUE_DEPTH = mcg_pkg::MCG_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // [3:0] month, [17:4] year, [23:18] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [5:0] slot_index, [14:6] day_value, [15] zero
  output logic        m_tuser,    // [0] blank
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import mcg_pkg::*;

  logic       monday_first, ordinal_numbering;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  mcg_entry_t push_entry, pop_entry;
  logic [5:0] out_slot;
  logic [8:0] out_day;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      monday_first      <= 1'b0;
      ordinal_numbering <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MONDAY_FIRST: monday_first      <= cfg_data;
        CFG_ORDINAL:      ordinal_numbering <= cfg_data;
        default:          ;
      endcase
    end
  end

  mcg_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .in_month          (s_tdata[3:0]),
    .in_year           (s_tdata[17:4]),
    .monday_first      (monday_first),
    .ordinal_numbering (ordinal_numbering),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_entry        (push_entry)
  );

  mcg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  mcg_back u_back (
    .clk               (clk),
    .rst               (rst),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_entry         (pop_entry),
    .monday_first      (monday_first),
    .ordinal_numbering (ordinal_numbering),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_slot          (out_slot),
    .out_blank         (m_tuser),
    .out_day           (out_day),
    .out_last          (m_tlast)
  );

  assign m_tdata = {1'b0, out_day, out_slot};

endmodule
